// ===== rtl/core/gf2m_inverse_ext_euclid_defines.svh =====
// ----------------------------------------------------------------------------
// GF(2^m) inverter assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GF2M_INVERSE_EXT_EUCLID_DEFINES_SVH
`define GF2M_INVERSE_EXT_EUCLID_DEFINES_SVH

`ifndef SYNTHESIS
`define GIEE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gf2m inverter: implication check failed");
`define GIEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gf2m inverter: next-cycle check failed");
`else
`define GIEE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GIEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/giee_pkg.sv =====
// ----------------------------------------------------------------------------
// GF(2^m) inverter package
// Widths, reset constant, control types and the degree helper.
// ----------------------------------------------------------------------------
`default_nettype none

package giee_pkg;

	localparam int FIELD_BITS = 10;
	localparam int MOD_BITS   = FIELD_BITS + 1;
	localparam int DEG_BITS   = $clog2(MOD_BITS);

	localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1033);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic r_cur_zero;
	} sts_t;

	// Index of the highest set bit; 0 for a zero word (callers test for zero).
	function automatic logic [DEG_BITS-1:0] poly_deg(input logic [MOD_BITS-1:0] p);
		logic [DEG_BITS-1:0] d;
		d = '0;
		for (int i = 0; i < MOD_BITS; i++) begin
			if (p[i]) begin
				d = DEG_BITS'(i);
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/giee_ctrl.sv =====
// ----------------------------------------------------------------------------
// GF(2^m) inverter controller
// Sequences load, Euclid steps and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module giee_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire giee_pkg::sts_t sts,
	output giee_pkg::cmd_t     cmd
);
	import giee_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.r_cur_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/giee_dp.sv =====
// ----------------------------------------------------------------------------
// GF(2^m) inverter datapath
// Remainder and Bezout registers with one shift-and-cancel or swap step per cycle while a step is commanded.
// ----------------------------------------------------------------------------
`default_nettype none

module giee_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire giee_pkg::cmd_t                      cmd,
	output giee_pkg::sts_t                           sts,
	input  wire logic                                cfg_wr_en,
	input  wire logic [giee_pkg::MOD_BITS-1:0]       cfg_wr_data,
	input  wire logic [giee_pkg::FIELD_BITS-1:0]     operand,
	output logic      [giee_pkg::FIELD_BITS-1:0]     inverse,
	output logic                                     has_inverse
);
	import giee_pkg::*;

	logic [MOD_BITS-1:0]   mod_q;
	logic [MOD_BITS-1:0]   r_prev_q, r_cur_q;
	// Only the low field bits of the Bezout track reach the result, and
	// carry-less products never move high bits downwards.
	logic [FIELD_BITS-1:0] w_prev_q, w_cur_q;
	logic                  nz_q;

	logic [DEG_BITS-1:0]   deg_p, deg_c, sh;
	logic                  reduce;

	assign deg_p  = poly_deg(r_prev_q);
	assign deg_c  = poly_deg(r_cur_q);
	assign reduce = (r_prev_q != '0) && (deg_p >= deg_c);
	assign sh     = deg_p - deg_c;

	assign sts.r_cur_zero = (r_cur_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RESET;
		end else if (cfg_wr_en) begin
			mod_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_prev_q <= mod_q;
			r_cur_q  <= {1'b0, operand};
			w_prev_q <= '0;
			w_cur_q  <= FIELD_BITS'(1);
			nz_q     <= (operand != '0);
		end else if (cmd.step) begin
			if (reduce) begin
				r_prev_q <= r_prev_q ^ (r_cur_q << sh);
				w_prev_q <= w_prev_q ^ (w_cur_q << sh);
			end else begin
				// division finished: rotate remainders and coefficients
				r_prev_q <= r_cur_q;
				r_cur_q  <= r_prev_q;
				w_prev_q <= w_cur_q;
				w_cur_q  <= w_prev_q;
			end
		end
	end

	assign has_inverse = nz_q && (r_prev_q == MOD_BITS'(1));
	assign inverse     = has_inverse ? w_prev_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/gf2m_inverse_ext_euclid.sv =====
// ----------------------------------------------------------------------------
// GF(2^10) inverter, extended Euclid
// Computes operand^-1 modulo the configured degree-ten polynomial.
// ----------------------------------------------------------------------------
// One operand is taken at a time. After the input beat the datapath runs one
// shift-and-cancel or swap step per cycle until the remainder is zero; for
// ten-bit operands that is at most 30 steps (20 cancels, 10 swaps). The result
// beat follows once the remainder is zero (with no steps for a zero operand)
// and is held through any output stall. The input stays stalled until the
// result beat is taken; the next input beat is then accepted back in idle.
// has_inverse is 1 when the final gcd is 1; otherwise inverse reads 0.
// The modulus register (reset x^10+x^3+1) may be written only while idle.
`default_nettype none

`include "gf2m_inverse_ext_euclid_defines.svh"

module gf2m_inverse_ext_euclid (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [giee_pkg::FIELD_BITS-1:0] operand,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [giee_pkg::FIELD_BITS-1:0] inverse,
	output logic                                 has_inverse,
	input  wire logic                            cfg_wr_en,
	input  wire logic [giee_pkg::MOD_BITS-1:0]   cfg_wr_data
);
	import giee_pkg::*;

	cmd_t cmd;
	sts_t sts;

	giee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	giee_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.operand     (operand),
		.inverse     (inverse),
		.has_inverse (has_inverse)
	);

	`GIEE_ASSERT_IMPL(a_no_inv_zero, clk, arst_n, out_valid && !has_inverse, inverse == '0)
	`GIEE_ASSERT_IMPL(a_one_in_flight, clk, arst_n, out_valid, in_stall)
	`GIEE_ASSERT_NEXT(a_accept_runs, clk, arst_n, in_valid && !in_stall, !out_valid && in_stall)
	`GIEE_ASSERT_IMPL(a_step_needs_rem, clk, arst_n, cmd.step, !sts.r_cur_zero && !cmd.load)

endmodule

`default_nettype wire
